/* rtl/pvd_pkg.sv */
// Package for the polyline vertex de-duplication block.
// Holds the request structs, result kind codes, register indexes and size constants.
// Depends on nothing; imported by polyline_vertex_dedup and its testbench.
`default_nettype none

package pvd_pkg;

	localparam int MAX_VERTICES_DEF = 65536;

	// Result queue depth, a power of two of at least three.
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [16:0] PART_CNT_MAX = 17'h1FFFF;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_PART   = 2'd1;
	localparam logic [1:0] KIND_CLOSE  = 2'd2;

	localparam logic [0:0] REG_MULTIPART = 1'd0;
	localparam logic [0:0] REG_MIN_PART  = 1'd1;

	typedef struct packed {
		logic [15:0]        vert_x;
		logic [15:0]        vert_y;
		logic signed [31:0] vert_z;
		logic               part_end;
		logic               geom_end;
	} vert_req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        slot;
		logic [15:0]        out_x;
		logic [15:0]        out_y;
		logic signed [31:0] out_z;
		logic [16:0]        offset_value;
		logic               run_last;
	} res_req_t;

endpackage

`default_nettype wire

/* rtl/polyline_vertex_dedup.sv */
// Top level of the polyline vertex de-duplication block.
// Holds the per-part tracking state, the result queue and the configuration registers.
// Depends on pvd_pkg for request structs, codes and constants.
`default_nettype none

// Removes consecutive duplicate vertices from a stream of quantised vertices and turns
// each kept vertex into a write to its compacted index. In multi-part mode every part is
// de-duplicated on its own, a part with too few kept vertices is discarded (its slots are
// reused by the next part) and a kept part produces a part offset request; the end of the
// geometry always produces a closing request with the total. Each vertex request is
// evaluated in the cycle it is accepted and gives zero to three result requests, which
// are pushed into a four-entry result queue; the queue hands out one result request per
// cycle while out_stall is low. A vertex request is accepted in any cycle in which the
// queue holds at most one request, so a stream whose vertices give one result each runs
// at one request per cycle while out_stall is low, and a vertex that gives more than one
// result stalls the input until the queue holds at most one request again. The results are
// registered in the queue and offered in order. Configuration writes take effect on the next accepted vertex.
module polyline_vertex_dedup
	import pvd_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_index,
	input  wire logic [3:0] cfg_data,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire vert_req_t in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output res_req_t       out_data
);

	// Index width: holds every value from zero up to the buffer size itself.
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [CW-1:0]  MAX_IDX  = CW'(MAX_VERTICES);
	localparam logic [CW-1:0]  LAST_IDX = CW'(MAX_VERTICES - 1);
	localparam logic [CW:0]    MAX_WIDE = (CW + 1)'(MAX_VERTICES);

	// Configuration registers.
	logic       multipart_q;
	logic [3:0] min_part_q;

	// Tracking state of the current part and geometry.
	logic [15:0]   last_x_q;
	logic [15:0]   last_y_q;
	logic [CW-1:0] part_base_q;
	logic [CW-1:0] part_cnt_q;
	logic [16:0]   kept_parts_q;
	logic          part_open_q;

	// Result queue.
	res_req_t             res_mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] res_cnt_q;

	logic in_acc;
	logic out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multipart_q <= 1'b0;
			min_part_q  <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MULTIPART: multipart_q <= cfg_data[0];
				REG_MIN_PART:  min_part_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Per-vertex evaluation, all from the current state and the incoming request.
	logic          keep;
	logic [CW-1:0] vidx;
	logic          buf_full;
	logic [CW-1:0] vslot;
	logic [CW-1:0] cnt_new;
	logic          ends_part;
	logic          survive;
	logic [16:0]   parts_inc;
	logic [CW:0]   base_sum;
	logic [CW-1:0] base_inc;
	logic [16:0]   parts_new;
	logic [CW-1:0] base_new;
	logic [CW:0]   total_single;
	logic          v_en;
	logic          p_en;
	logic          c_en;
	res_req_t      res_v;
	res_req_t      res_p;
	res_req_t      res_c;

	always_comb begin
		keep     = !part_open_q || (in_data.vert_x != last_x_q) || (in_data.vert_y != last_y_q);
		vidx     = part_base_q + part_cnt_q;
		buf_full = (vidx >= MAX_IDX);
		vslot    = buf_full ? LAST_IDX : vidx;
		cnt_new  = part_cnt_q + CW'(keep && !buf_full);

		ends_part = multipart_q && (in_data.part_end || in_data.geom_end);
		survive   = (cnt_new >= CW'(min_part_q));
		parts_inc = (kept_parts_q < PART_CNT_MAX) ? kept_parts_q + 17'd1 : kept_parts_q;
		base_sum  = {1'b0, part_base_q} + {1'b0, cnt_new};
		base_inc  = (base_sum > MAX_WIDE) ? MAX_IDX : base_sum[CW-1:0];
		parts_new = (ends_part && survive) ? parts_inc : kept_parts_q;
		base_new  = (ends_part && survive) ? base_inc : part_base_q;
		total_single = base_sum;

		v_en = keep;
		p_en = ends_part && survive;
		c_en = in_data.geom_end;

		res_v.kind         = KIND_VERTEX;
		res_v.slot         = 32'(vslot) >> 0 == 0 ? 16'd0 : 16'(32'(vslot));
		res_v.out_x        = in_data.vert_x;
		res_v.out_y        = in_data.vert_y;
		res_v.out_z        = in_data.vert_z;
		res_v.offset_value = 17'd0;
		res_v.run_last     = !p_en && !c_en;

		res_p.kind         = KIND_PART;
		res_p.slot         = kept_parts_q[15:0];
		res_p.out_x        = 16'd0;
		res_p.out_y        = 16'd0;
		res_p.out_z        = 32'sd0;
		res_p.offset_value = 17'(32'(part_base_q));
		res_p.run_last     = !c_en;

		res_c.kind         = KIND_CLOSE;
		res_c.out_x        = 16'd0;
		res_c.out_y        = 16'd0;
		res_c.out_z        = 32'sd0;
		res_c.run_last     = 1'b1;
		if (multipart_q) begin
			res_c.slot         = parts_new[15:0];
			res_c.offset_value = 17'(32'(base_new));
		end else begin
			res_c.slot         = 16'd0;
			res_c.offset_value = 17'(32'(total_single));
		end
	end

	// The queue must have room for three requests before a vertex is taken.
	assign in_stall  = (res_cnt_q > RES_CNT_W'(RES_DEPTH - 3));
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (res_cnt_q != '0);
	assign out_acc   = out_valid && !out_stall;
	assign out_data  = res_mem[rd_ptr_q];

	logic [1:0]           push_n;
	logic [RES_PTR_W-1:0] p_pos;
	logic [RES_PTR_W-1:0] c_pos;

	always_comb begin
		push_n = 2'(v_en) + 2'(p_en) + 2'(c_en);
		p_pos  = wr_ptr_q + RES_PTR_W'(v_en);
		c_pos  = p_pos + RES_PTR_W'(p_en);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (v_en) begin
				res_mem[wr_ptr_q] <= res_v;
			end
			if (p_en) begin
				res_mem[p_pos] <= res_p;
			end
			if (c_en) begin
				res_mem[c_pos] <= res_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			res_cnt_q <= res_cnt_q + RES_CNT_W'(in_acc ? push_n : 2'd0)
			             - RES_CNT_W'(out_acc);
		end
	end

	// Tracking state: the end of the geometry returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q     <= '0;
			last_y_q     <= '0;
			part_base_q  <= '0;
			part_cnt_q   <= '0;
			kept_parts_q <= '0;
			part_open_q  <= 1'b0;
		end else if (in_acc) begin
			if (in_data.geom_end) begin
				last_x_q     <= '0;
				last_y_q     <= '0;
				part_base_q  <= '0;
				part_cnt_q   <= '0;
				kept_parts_q <= '0;
				part_open_q  <= 1'b0;
			end else begin
				if (keep) begin
					last_x_q <= in_data.vert_x;
					last_y_q <= in_data.vert_y;
				end
				if (ends_part) begin
					part_base_q  <= base_new;
					part_cnt_q   <= '0;
					kept_parts_q <= parts_new;
					part_open_q  <= 1'b0;
				end else begin
					part_cnt_q  <= cnt_new;
					part_open_q <= part_open_q || keep;
				end
			end
		end
	end

	// The queue never holds more requests than it has entries.
	a_res_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overfilled");

	// The compacted index of the current part never passes the buffer size.
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, part_base_q} + {1'b0, part_cnt_q}) <= MAX_WIDE)
		else $error("vertex index beyond buffer size");

	// The queue fill follows the pushes and pops exactly.
	a_res_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> res_cnt_q == $past(res_cnt_q) + RES_CNT_W'($past(in_acc) ? $past(push_n) : 2'd0)
		         - RES_CNT_W'($past(out_acc)))
		else $error("result queue count out of step");

	// After the end of a geometry the next vertex starts from clean state.
	a_geom_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.geom_end |=>
		part_base_q == '0 && part_cnt_q == '0 && kept_parts_q == '0 && !part_open_q)
		else $error("state not cleared at end of geometry");

	// Every accepted end of geometry yields a closing request as its last result.
	a_close_present: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.geom_end |-> c_en && res_c.run_last)
		else $error("closing request missing");

endmodule

`default_nettype wire

/* test/polyline_vertex_dedup_tb.sv */
// Self-checking testbench for the polyline vertex de-duplication block.
// Predicts every vertex, part offset and closing write and checks them in order.
// Depends on pvd_pkg and polyline_vertex_dedup only.

module polyline_vertex_dedup_tb;
	import pvd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VERT_LIMIT    = MAX_VERTICES_DEF;
	localparam int RESET_CYCLES  = 12;
	localparam int IDLE_PCT      = 11;
	// Cycles to let pass once nothing is expected: the block's latency plus margin.
	localparam int SETTLE_CYCLES = 4;
	// The longest legitimate quiet spell is the receiver's long hold-off below.
	localparam int STUCK_LIMIT   = 2000;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 120;
	localparam int CALM_FROM     = 300;
	localparam int CALM_TO       = 380;
	localparam int MAX_REPORTS   = 50;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 75;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [3:0]  cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	vert_req_t   in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	res_req_t    out_data;

	polyline_vertex_dedup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Vertex requests waiting to be offered, and the buffer writes that the block
	// owes us, oldest first.
	vert_req_t vertex_q[$];
	res_req_t  buffer_writes_q[$];

	// Our own copy of the configuration registers, starting at their reset values.
	logic        multipart_on = 1'b0;
	logic [3:0]  min_vertices = 4'd2;

	// Our own copy of the per-part tracking state.
	logic [15:0] last_x     = '0;
	logic [15:0] last_y     = '0;
	logic [16:0] part_base  = '0;
	logic [16:0] part_kept  = '0;
	logic [16:0] parts_kept = '0;
	logic        part_open  = 1'b0;

	logic        in_taken = 1'b0;
	int unsigned vertices_taken = 0;
	int unsigned writes_seen    = 0;
	int unsigned err_cnt        = 0;
	int unsigned stuck_cycles   = 0;
	int unsigned hold_left      = 0;
	logic        hold_done      = 1'b0;
	logic        calm;

	// Settings for the random phases, the extremes among them.
	logic        phase_mode[RANDOM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	logic [3:0]  phase_min[RANDOM_PHASES]  = '{4'd2, 4'd15, 4'd2, 4'd1, 4'd4, 4'd15};

	// A stretch of the run in which neither side idles, so that the block is seen
	// running flat out for a while.
	assign calm = (vertices_taken >= CALM_FROM) && (vertices_taken < CALM_TO);

	// Works out the buffer writes caused by one accepted vertex request and moves our
	// copy of the state on. The write for a kept vertex comes first, then
	// an offset write for a part that survives, then the closing write.
	function automatic void compact_vertex(input vert_req_t v);
		res_req_t    r;
		res_req_t    batch[$];
		logic [17:0] idx;
		// A vertex that opens a part is always kept; otherwise only a change of x or y
		// against the last kept vertex keeps it.
		if (!part_open || v.vert_x != last_x || v.vert_y != last_y) begin
			r = '0;
			r.kind = KIND_VERTEX;
			idx = part_base + part_kept;
			if (idx < VERT_LIMIT) begin
				r.slot = idx[15:0];
				part_kept = part_kept + 17'd1;
			end else begin
				// Buffer full: keep overwriting the last slot, the count stays put.
				r.slot = 16'(VERT_LIMIT - 1);
			end
			r.out_x = v.vert_x;
			r.out_y = v.vert_y;
			r.out_z = v.vert_z;
			batch.push_back(r);
			last_x = v.vert_x;
			last_y = v.vert_y;
			part_open = 1'b1;
		end
		// In single-part mode the end-of-part mark means nothing. In multi-part mode
		// the end of the geometry closes the part as well.
		if (multipart_on && (v.part_end || v.geom_end)) begin
			if (part_kept >= min_vertices) begin
				r = '0;
				r.kind = KIND_PART;
				r.slot = parts_kept[15:0];
				r.offset_value = part_base;
				batch.push_back(r);
				if (parts_kept != PART_CNT_MAX)
					parts_kept = parts_kept + 17'd1;
				idx = part_base + part_kept;
				part_base = (idx > VERT_LIMIT) ? 17'(VERT_LIMIT) : idx[16:0];
			end
			// A short part is simply forgotten: its slots get reused by the next one.
			part_kept = '0;
			part_open = 1'b0;
		end
		if (v.geom_end) begin
			r = '0;
			r.kind = KIND_CLOSE;
			if (multipart_on) begin
				r.slot = parts_kept[15:0];
				r.offset_value = part_base;
			end else begin
				r.slot = '0;
				r.offset_value = 17'(part_base + part_kept);
			end
			batch.push_back(r);
			last_x = '0;
			last_y = '0;
			part_base = '0;
			part_kept = '0;
			parts_kept = '0;
			part_open = 1'b0;
		end
		if (batch.size() != 0)
			batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[i])
			buffer_writes_q.push_back(batch[i]);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (err_cnt < MAX_REPORTS)
				$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endfunction

	// Sender. A request that has been offered stays put until the block takes it;
	// only then do we decide, at random, whether to offer the next one or idle.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (vertex_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_data  <= vertex_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver. Stalls at random, except once when it holds off for a long stretch so
	// that the result queue fills and the block has to stall its input.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && writes_seen >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Monitor. Everything is sampled at the rising edge, where inputs set at the
	// falling edge and the block's registered outputs are both settled.
	always @(posedge clk) begin
		res_req_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			compact_vertex(in_data);
			vertices_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (buffer_writes_q.size() == 0) begin
				if (err_cnt < MAX_REPORTS)
					$error("result with nothing expected: kind %0d, slot %0h",
						out_data.kind, out_data.slot);
				err_cnt++;
			end else begin
				want = buffer_writes_q.pop_front();
				check_field("kind", want.kind, out_data.kind);
				check_field("slot", want.slot, out_data.slot);
				check_field("out_x", want.out_x, out_data.out_x);
				check_field("out_y", want.out_y, out_data.out_y);
				check_field("out_z", want.out_z, out_data.out_z);
				check_field("offset_value", want.offset_value, out_data.offset_value);
				check_field("run_last", want.run_last, out_data.run_last);
			end
			writes_seen++;
		end
		// Watchdog: a long spell with no request moving on either side means a hang.
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_vertex(input logic [15:0] x, input logic [15:0] y,
			input logic [31:0] z, input logic pe, input logic ge);
		vert_req_t v;
		v.vert_x   = x;
		v.vert_y   = y;
		v.vert_z   = z;
		v.part_end = pe;
		v.geom_end = ge;
		vertex_q.push_back(v);
	endtask

	// Waits until every queued request has gone in and every write has come out,
	// then lets SETTLE_CYCLES pass as well, since a dropped vertex gives nothing
	// to wait for.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (vertex_q.size() != 0 || in_valid || buffer_writes_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only ever called while the block is idle, so our copy may change at once.
	task automatic write_reg(input logic idx, input logic [3:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_MULTIPART)
			multipart_on = val[0];
		else
			min_vertices = val;
	endtask

	// Mostly well-formed geometries of a few parts, with repeated vertices sprinkled
	// in and coordinates often drawn from a tiny range so that duplicates happen
	// across parts too; the rest is loose vertices with random marks.
	task automatic queue_traffic(input int unsigned count);
		int unsigned made;
		int unsigned parts;
		int unsigned len;
		logic [15:0] px;
		logic [15:0] py;
		logic        last_part;
		logic        last_vert;
		made = 0;
		px = '0;
		py = '0;
		while (made < count) begin
			if ($urandom_range(99) < 15) begin
				push_vertex(16'($urandom), 16'($urandom), $urandom,
					1'($urandom_range(1)), $urandom_range(9) == 0);
				made++;
			end else begin
				parts = $urandom_range(1, 4);
				for (int p = 0; p < parts; p++) begin
					len = $urandom_range(1, min_vertices + 3);
					last_part = (p == parts - 1);
					for (int j = 0; j < len; j++) begin
						last_vert = (j == len - 1);
						if (j == 0 || $urandom_range(99) >= 30) begin
							px = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
							py = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
						end
						// The geometry's own end closes the part, so its part mark
						// is sometimes left off.
						push_vertex(px, py, $urandom,
							last_vert && (!last_part || $urandom_range(3) != 0),
							last_vert && last_part);
						made++;
					end
				end
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, single part: the first vertex is kept even though it equals
		// the cleared last vertex, part marks are ignored, and the geometry ends on a
		// dropped duplicate.
		push_vertex(16'h0000, 16'h0000, 32'h8000_0000, 1'b0, 1'b0);
		push_vertex(16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0);
		push_vertex(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
		push_vertex(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		push_vertex(16'hFFFF, 16'h0000, 32'h0000_0005, 1'b0, 1'b1);
		wait_idle();

		// Multi-part, minimum of two: a short part is discarded and overwritten, a
		// surviving part writes its offset, and a geometry closes on a short part.
		write_reg(REG_MULTIPART, 4'd1);
		write_reg(REG_MIN_PART, 4'd2);
		push_vertex(16'd5, 16'd5, 32'd11, 1'b0, 1'b0);
		push_vertex(16'd5, 16'd5, 32'd12, 1'b1, 1'b0);
		push_vertex(16'd5, 16'd5, 32'd13, 1'b0, 1'b0);
		push_vertex(16'd6, 16'd5, 32'd14, 1'b0, 1'b0);
		push_vertex(16'd6, 16'd5, 32'd15, 1'b1, 1'b0);
		push_vertex(16'd1, 16'd2, 32'd16, 1'b1, 1'b1);
		push_vertex(16'd3, 16'd3, 32'd17, 1'b0, 1'b0);
		wait_idle();

		// A minimum of zero lets every part through; the one-vertex part that also
		// ends the geometry gives all three writes.
		write_reg(REG_MIN_PART, 4'd0);
		push_vertex(16'd9, 16'd9, 32'd18, 1'b1, 1'b0);
		push_vertex(16'd9, 16'd9, 32'd19, 1'b1, 1'b1);
		push_vertex(16'd3, 16'd3, 32'd20, 1'b0, 1'b0);
		wait_idle();

		// Mode switched half-way through a geometry: the open part carries on as the
		// single part.
		write_reg(REG_MULTIPART, 4'd0);
		push_vertex(16'd3, 16'd3, 32'd21, 1'b0, 1'b0);
		push_vertex(16'd4, 16'd4, 32'd22, 1'b1, 1'b1);
		wait_idle();

		// Random traffic over several settings, the extremes among them. In the second
		// phase the sender stops half-way until every write has come back.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_MULTIPART, {3'd0, phase_mode[p]});
			write_reg(REG_MIN_PART, phase_min[p]);
			if (p == 1) begin
				queue_traffic(PHASE_ITEMS / 2);
				wait_idle();
				queue_traffic(PHASE_ITEMS / 2);
			end else begin
				queue_traffic(PHASE_ITEMS);
			end
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0 && buffer_writes_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
